// ===== rtl/core/ftsa_pkg.sv =====
// shared types, codes and constants of the four-table slot allocator
package ftsa_pkg;

  localparam int unsigned MAX_SLOTS_DEF = 1024;
  localparam int unsigned KINDS         = 4;

  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned STRIDE_W = 9;
  localparam int unsigned OFFS_W   = 19;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned SUM_W    = 12;
  localparam int unsigned PROD_W   = STRIDE_W + SUM_W;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_TEXTURE = 2'd0,
    KIND_BUFFER  = 2'd1,
    KIND_TARGET  = 2'd2,
    KIND_DEPTH   = 2'd3
  } kind_e;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [2:0] {
    REG_TEXTURE_CAP  = 3'd0,
    REG_BUFFER_CAP   = 3'd1,
    REG_TARGET_CAP   = 3'd2,
    REG_DEPTH_CAP    = 3'd3,
    REG_VIEW_STRIDE  = 3'd4,
    REG_TARGET_STRIDE = 3'd5,
    REG_DEPTH_STRIDE = 3'd6,
    REG_BUFFER_BASE  = 3'd7
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MUL
  } state_e;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 9'd32;

endpackage

// ===== rtl/core/four_table_slot_allocator.sv =====
// top level of the four-table slot allocator
//
// Four LIFO free lists of slot numbers (textures, buffers, render targets,
// depth stencils) share one single-port stack RAM of 4*MAX_SLOTS 10-bit
// entries; the free counts sit in flip-flops. Each input word passes three
// steps: the accept cycle updates the count and drives the stack RAM, the
// second takes the RAM read data and selects the slot, the third runs the
// stride multiply into the output register, waiting while the output is held.
// A new word is accepted as soon as the previous result is in the output
// register, so no new word is taken while one is in flight. Init completes in its
// accept cycle: a per-table low-water mark records the entries left untouched
// since init, whose contents follow from the init capacity, so the RAM needs
// no fill or clearing pass after reset or init.
module four_table_slot_allocator #(
  parameter int unsigned MAX_SLOTS = ftsa_pkg::MAX_SLOTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [15:0]                  s_axis_tdata,  // slot_in
  input  logic [3:0]                   s_axis_tuser,  // operation, kind
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [47:0]                  m_axis_tdata,  // slot_out, byte_offset, status, free_left
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_idx_i,
  input  logic [ftsa_pkg::CFG_W-1:0]   cfg_data_i
);

  import ftsa_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_SLOTS);
  localparam int unsigned PW  = (AW > CNT_W) ? AW : CNT_W;
  localparam int unsigned RAW = $clog2(KINDS * MAX_SLOTS);

  function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] c);
    if (32'(c) > MAX_SLOTS) begin
      return CNT_W'(MAX_SLOTS);
    end
    return c;
  endfunction

  function automatic logic [RAW-1:0] stack_addr(input logic [1:0] k,
                                                input logic [CNT_W-1:0] p);
    logic [PW-1:0] pw;
    pw = PW'(p);
    return {k, pw[AW-1:0]};
  endfunction

  // configuration registers
  logic [CNT_W-1:0]    cap_q [KINDS];
  logic [STRIDE_W-1:0] view_stride_q, target_stride_q, depth_stride_q;
  logic [CNT_W-1:0]    buffer_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < KINDS; t++) begin
        cap_q[t] <= '0;
      end
      view_stride_q   <= STRIDE_RESET;
      target_stride_q <= STRIDE_RESET;
      depth_stride_q  <= STRIDE_RESET;
      buffer_base_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_TEXTURE_CAP:   cap_q[KIND_TEXTURE] <= cfg_data_i;
        REG_BUFFER_CAP:    cap_q[KIND_BUFFER]  <= cfg_data_i;
        REG_TARGET_CAP:    cap_q[KIND_TARGET]  <= cfg_data_i;
        REG_DEPTH_CAP:     cap_q[KIND_DEPTH]   <= cfg_data_i;
        REG_VIEW_STRIDE:   view_stride_q       <= cfg_data_i[STRIDE_W-1:0];
        REG_TARGET_STRIDE: target_stride_q     <= cfg_data_i[STRIDE_W-1:0];
        REG_DEPTH_STRIDE:  depth_stride_q      <= cfg_data_i[STRIDE_W-1:0];
        REG_BUFFER_BASE:   buffer_base_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input word fields
  op_e              in_op;
  logic [1:0]       in_kind;
  logic [SLOT_W-1:0] in_slot;
  logic             in_acc;

  assign in_op   = op_e'(s_axis_tuser[1:0]);
  assign in_kind = s_axis_tuser[3:2];
  assign in_slot = s_axis_tdata[SLOT_W-1:0];
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  // state machine
  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_LOOK;
      ST_LOOK: state_d = ST_MUL;
      ST_MUL:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  logic out_load;

  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_LOOK: ;
      ST_MUL:  out_load = out_free;
      default: ;
    endcase
  end

  // per-table counts, low-water marks and init capacities
  logic [CNT_W-1:0] cnt_q [KINDS], cnt_d [KINDS];
  logic [CNT_W-1:0] lw_q [KINDS], lw_d [KINDS];
  logic [CNT_W-1:0] initc_q [KINDS], initc_d [KINDS];

  logic [CNT_W-1:0] cur_cnt, cur_cap, cur_lw, cur_initc, pop_pos;
  logic             ram_en, ram_we;
  logic [RAW-1:0]   ram_addr;
  logic [SLOT_W-1:0] ram_rdata;

  logic [STAT_W-1:0] status_d;
  logic [CNT_W-1:0]  left_d;
  logic              hit_d, use_init_d;
  logic [SLOT_W-1:0] init_val_d;

  assign cur_cnt   = cnt_q[in_kind];
  assign cur_cap   = eff_cap(cap_q[in_kind]);
  assign cur_lw    = lw_q[in_kind];
  assign cur_initc = initc_q[in_kind];
  assign pop_pos   = cur_cnt - CNT_W'(1);

  always_comb begin
    for (int t = 0; t < KINDS; t++) begin
      cnt_d[t]   = cnt_q[t];
      lw_d[t]    = lw_q[t];
      initc_d[t] = initc_q[t];
    end
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = stack_addr(in_kind, cur_cnt);
    status_d   = STAT_OK;
    left_d     = cur_cnt;
    hit_d      = 1'b0;
    use_init_d = 1'b0;
    init_val_d = SLOT_W'(cur_initc - cur_cnt);
    if (in_acc) begin
      case (in_op)
        OP_INIT: begin
          for (int t = 0; t < KINDS; t++) begin
            cnt_d[t]   = eff_cap(cap_q[t]);
            lw_d[t]    = eff_cap(cap_q[t]);
            initc_d[t] = eff_cap(cap_q[t]);
          end
          left_d = cur_cap;
        end
        OP_ALLOC: begin
          if (cur_cnt == '0) begin
            status_d = STAT_EMPTY;
          end else begin
            hit_d          = 1'b1;
            cnt_d[in_kind] = pop_pos;
            left_d         = pop_pos;
            use_init_d     = pop_pos < cur_lw;
            if (pop_pos < cur_lw) begin
              lw_d[in_kind] = pop_pos;
            end
            ram_en   = 1'b1;
            ram_addr = stack_addr(in_kind, pop_pos);
          end
        end
        OP_FREE: begin
          if (cur_cnt >= cur_cap) begin
            status_d = STAT_FULL;
          end else begin
            hit_d          = 1'b1;
            cnt_d[in_kind] = cur_cnt + CNT_W'(1);
            left_d         = cur_cnt + CNT_W'(1);
            ram_en         = 1'b1;
            ram_we         = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  ftsa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (KINDS * MAX_SLOTS)
  ) u_stack (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_slot),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      for (int t = 0; t < KINDS; t++) begin
        cnt_q[t]   <= '0;
        lw_q[t]    <= '0;
        initc_q[t] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      for (int t = 0; t < KINDS; t++) begin
        cnt_q[t]   <= cnt_d[t];
        lw_q[t]    <= lw_d[t];
        initc_q[t] <= initc_d[t];
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // word in flight
  op_e               op_q;
  logic [1:0]        kind_q;
  logic [SLOT_W-1:0] slot_in_q, init_val_q, slot_q;
  logic [STAT_W-1:0] status_q;
  logic [CNT_W-1:0]  left_q;
  logic              hit_q, use_init_q;
  logic [STRIDE_W-1:0] stride_q;
  logic [SUM_W-1:0]  sum_q;

  logic [SLOT_W-1:0]   slot_sel;
  logic [CNT_W-1:0]    base_sel;
  logic [STRIDE_W-1:0] stride_sel;
  logic [PROD_W-1:0]   prod;

  always_comb begin
    slot_sel = '0;
    if (hit_q) begin
      if (op_q == OP_FREE) begin
        slot_sel = slot_in_q;
      end else if (use_init_q) begin
        slot_sel = init_val_q;
      end else begin
        slot_sel = ram_rdata;
      end
    end
    base_sel = '0;
    case (kind_e'(kind_q))
      KIND_TEXTURE: stride_sel = view_stride_q;
      KIND_BUFFER: begin
        stride_sel = view_stride_q;
        base_sel   = buffer_base_q;
      end
      KIND_TARGET:  stride_sel = target_stride_q;
      default:      stride_sel = depth_stride_q;
    endcase
  end

  assign prod = PROD_W'(stride_q) * PROD_W'(sum_q);

  logic [SLOT_W-1:0] out_slot_q;
  logic [OFFS_W-1:0] out_offs_q;
  logic [STAT_W-1:0] out_stat_q;
  logic [CNT_W-1:0]  out_left_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q       <= in_op;
      kind_q     <= in_kind;
      slot_in_q  <= in_slot;
      status_q   <= status_d;
      left_q     <= left_d;
      hit_q      <= hit_d;
      use_init_q <= use_init_d;
      init_val_q <= init_val_d;
    end
    if (state_q == ST_LOOK) begin
      slot_q   <= slot_sel;
      stride_q <= stride_sel;
      sum_q    <= SUM_W'(base_sel) + SUM_W'(slot_sel);
    end
    if (out_load) begin
      out_slot_q <= slot_q;
      out_offs_q <= hit_q ? prod[OFFS_W-1:0] : '0;
      out_stat_q <= status_q;
      out_left_q <= left_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_left_q, out_stat_q, out_offs_q, out_slot_q};

`ifndef NO_ASSERTIONS
  for (genvar g = 0; g < KINDS; g++) begin : g_chk
    a_lw_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
      lw_q[g] <= cnt_q[g] && lw_q[g] <= initc_q[g])
      else $error("low-water mark above count or init capacity");
  end

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready && state_q == ST_LOOK)
    else $error("accepted word did not start the lookup");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_stat_q != STAT_OK) |-> (out_slot_q == '0 && out_offs_q == '0))
    else $error("error result carries a slot or offset");

  a_ram_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_en |-> state_q == ST_IDLE)
    else $error("stack access outside the accept cycle");
`endif

endmodule

// ===== rtl/core/ftsa_ram.sv =====
// generic single-port ram with registered read
module ftsa_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule
